### design/evr_pkg.sv
// ----------------------------------------------------------------------------
// evr_pkg
// Shared widths, payload types and register indexes for the Euler vertex
// rotation block.
// ----------------------------------------------------------------------------
package evr_pkg;

   // Vertex coordinates, signed Q16.8
   localparam int COORD_WIDTH = 24;
   // Trig values, signed Q1.14 (two integer bits incl. sign)
   localparam int TRIG_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_X = 3'd0,
      CSR_SIN_X = 3'd1,
      CSR_COS_Y = 3'd2,
      CSR_SIN_Y = 3'd3,
      CSR_COS_Z = 3'd4,
      CSR_SIN_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vert_x;
      logic signed [COORD_WIDTH-1:0] vert_y;
      logic signed [COORD_WIDTH-1:0] vert_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rot_x;
      logic signed [COORD_WIDTH-1:0] rot_y;
      logic signed [COORD_WIDTH-1:0] rot_z;
   } rsp_payload_type;

endpackage

### design/euler_vertex_rotation.sv
// ----------------------------------------------------------------------------
// euler_vertex_rotation
// Rotates one Q16.8 vertex about Y, then X, then Z with Q1.14 cos/sin
// registers; final coordinates saturate to the payload width.
// ----------------------------------------------------------------------------
//
//   channel  ports          direction  carries
//   -------  -------------  ---------  ---------------------------------------
//   req      req_*          in         vertex request (vert_x, vert_y, vert_z)
//   rsp      rsp_*          out        rotated vertex (rot_x, rot_y, rot_z)
//   csr      csr_*          in         cos/sin register writes, index 0..5
//
// Cycles: one request per clock while no response waits on rsp_ready. The
//   response passes through seven register stages, the first loaded at the
//   accepting edge; two per axis (multiply, then shift/add) and one for
//   saturation into the output register.
// Reset: synchronous; clears all stage valids, trig registers go to cos = 1.0
//   and sin = 0.0 (identity rotation).
// Stalls: the whole pipeline holds while a response waits on rsp_ready;
//   req_ready drops in the same cycle. csr writes are always taken and are
//   meant to happen with the pipeline empty.
// ----------------------------------------------------------------------------
module euler_vertex_rotation #(
   parameter int TRIG_WIDTH = evr_pkg::TRIG_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  evr_pkg::req_payload_type             req_payload,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output evr_pkg::rsp_payload_type             rsp_payload,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [evr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [TRIG_WIDTH-1:0]                csr_wdata
);

   localparam int CW = evr_pkg::COORD_WIDTH;
   localparam int TF = TRIG_WIDTH - 2;
   // exact widths after each axis; each axis adds three bits of growth
   localparam int W1 = CW + 3;
   localparam int W2 = CW + 6;
   localparam int W3 = CW + 9;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1 << TF);

   // --------------------------------------------------------------------
   // Trig registers
   // --------------------------------------------------------------------
   logic signed [TRIG_WIDTH-1:0] cos_x_in, cos_x_ff, sin_x_in, sin_x_ff;
   logic signed [TRIG_WIDTH-1:0] cos_y_in, cos_y_ff, sin_y_in, sin_y_ff;
   logic signed [TRIG_WIDTH-1:0] cos_z_in, cos_z_ff, sin_z_in, sin_z_ff;
   logic                         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      cos_x_in = cos_x_ff;
      sin_x_in = sin_x_ff;
      cos_y_in = cos_y_ff;
      sin_y_in = sin_y_ff;
      cos_z_in = cos_z_ff;
      sin_z_in = sin_z_ff;
      if (csr_write) begin
         case (csr_index)
            evr_pkg::CSR_COS_X: cos_x_in = csr_wdata;
            evr_pkg::CSR_SIN_X: sin_x_in = csr_wdata;
            evr_pkg::CSR_COS_Y: cos_y_in = csr_wdata;
            evr_pkg::CSR_SIN_Y: sin_y_in = csr_wdata;
            evr_pkg::CSR_COS_Z: cos_z_in = csr_wdata;
            evr_pkg::CSR_SIN_Z: sin_z_in = csr_wdata;
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff <= TRIG_ONE;
         sin_x_ff <= '0;
         cos_y_ff <= TRIG_ONE;
         sin_y_ff <= '0;
         cos_z_ff <= TRIG_ONE;
         sin_z_ff <= '0;
      end else begin
         cos_x_ff <= cos_x_in;
         sin_x_ff <= sin_x_in;
         cos_y_ff <= cos_y_in;
         sin_y_ff <= sin_y_in;
         cos_z_ff <= cos_z_in;
         sin_z_ff <= sin_z_in;
      end
   end

   // --------------------------------------------------------------------
   // Pipeline control: one enable for every stage. Advance whenever the
   // output register is empty or being drained.
   // --------------------------------------------------------------------
   logic pipe_en;

   assign pipe_en   = ~rsp_valid | rsp_ready;
   assign req_ready = pipe_en;

   // --------------------------------------------------------------------
   // Y axis: x1 = t(x*cy) - t(z*sy), z1 = t(z*cy) + t(x*sy); y rides along
   // --------------------------------------------------------------------
   logic                 y_valid;
   logic signed [W1-1:0] x1, z1;
   logic signed [CW-1:0] y0;

   evr_rot_stage #(
      .AW (CW),
      .BW (CW),
      .PW (CW),
      .TW (TRIG_WIDTH)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .a         (req_payload.vert_x),
      .b         (req_payload.vert_z),
      .p         (req_payload.vert_y),
      .c         (cos_y_ff),
      .s         (sin_y_ff),
      .out_valid (y_valid),
      .u         (x1),
      .v         (z1),
      .p_out     (y0)
   );

   // --------------------------------------------------------------------
   // X axis: y1 = t(y*cx) - t(z1*sx), z2 = t(z1*cx) + t(y*sx); x1 rides
   // --------------------------------------------------------------------
   logic                 x_valid;
   logic signed [W2-1:0] y1, z2;
   logic signed [W1-1:0] x1_d;

   evr_rot_stage #(
      .AW (CW),
      .BW (W1),
      .PW (W1),
      .TW (TRIG_WIDTH)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (y_valid),
      .a         (y0),
      .b         (z1),
      .p         (x1),
      .c         (cos_x_ff),
      .s         (sin_x_ff),
      .out_valid (x_valid),
      .u         (y1),
      .v         (z2),
      .p_out     (x1_d)
   );

   // --------------------------------------------------------------------
   // Z axis: y2 = t(y1*cz) - t(x1*sz), x2 = t(x1*cz) + t(y1*sz); z2 rides
   // --------------------------------------------------------------------
   logic                 z_valid;
   logic signed [W3-1:0] y2, x2;
   logic signed [W2-1:0] z2_d;

   evr_rot_stage #(
      .AW (W2),
      .BW (W1),
      .PW (W2),
      .TW (TRIG_WIDTH)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (x_valid),
      .a         (y1),
      .b         (x1_d),
      .p         (z2),
      .c         (cos_z_ff),
      .s         (sin_z_ff),
      .out_valid (z_valid),
      .u         (y2),
      .v         (x2),
      .p_out     (z2_d)
   );

   // --------------------------------------------------------------------
   // Saturate to the payload width, output register
   // --------------------------------------------------------------------
   evr_sat_stage #(
      .IW (W3)
   ) u_sat (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (z_valid),
      .x           (x2),
      .y           (y2),
      .z           (W3'(z2_d)),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload)
   );

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a finished rotation always lands in the output register
   a_z_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (z_valid && pipe_en) |=> rsp_valid)
      else $error("item lost between last axis and output register");

   // a stall freezes the valid of every axis output
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable({y_valid, x_valid, z_valid}))
      else $error("pipeline moved during stall");

endmodule

### design/evr_rot_stage.sv
// ----------------------------------------------------------------------------
// evr_rot_stage
// Planar rotation about one axis, two register stages:
//   u = t(a*c) - t(b*s),  v = t(b*c) + t(a*s),  p passed along.
// t() keeps the product floor-shifted by the trig fraction bits.
// ----------------------------------------------------------------------------
module evr_rot_stage #(
   parameter int AW = evr_pkg::COORD_WIDTH,
   parameter int BW = evr_pkg::COORD_WIDTH,
   parameter int PW = evr_pkg::COORD_WIDTH,
   parameter int TW = evr_pkg::TRIG_WIDTH,
   localparam int OW = ((AW > BW) ? AW : BW) + 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   input  logic signed [PW-1:0] p,
   input  logic signed [TW-1:0] c,
   input  logic signed [TW-1:0] s,
   output logic                 out_valid,
   output logic signed [OW-1:0] u,
   output logic signed [OW-1:0] v,
   output logic signed [PW-1:0] p_out
);

   localparam int TF  = TW - 2;
   localparam int PAW = AW + TW;
   localparam int PBW = BW + TW;

   // multiply stage
   logic                  valid_mid_ff;
   logic signed [PAW-1:0] prod_ac_in, prod_ac_ff, prod_as_in, prod_as_ff;
   logic signed [PBW-1:0] prod_bc_in, prod_bc_ff, prod_bs_in, prod_bs_ff;
   logic signed [PW-1:0]  p_mid_ff;

   // add stage
   logic                  valid_out_ff;
   logic signed [OW-1:0]  u_in, u_ff, v_in, v_ff;
   logic signed [PW-1:0]  p_out_ff;

   always_comb begin
      prod_ac_in = PAW'(a * c);
      prod_as_in = PAW'(a * s);
      prod_bc_in = PBW'(b * c);
      prod_bs_in = PBW'(b * s);
   end

   // dropping the low TF bits of a two's complement product is a floor shift
   always_comb begin
      u_in = OW'(signed'(prod_ac_ff[PAW-1:TF])) - OW'(signed'(prod_bs_ff[PBW-1:TF]));
      v_in = OW'(signed'(prod_bc_ff[PBW-1:TF])) + OW'(signed'(prod_as_ff[PAW-1:TF]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mid_ff <= 1'b0;
         valid_out_ff <= 1'b0;
      end else if (en) begin
         valid_mid_ff <= in_valid;
         valid_out_ff <= valid_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ac_ff <= prod_ac_in;
         prod_as_ff <= prod_as_in;
         prod_bc_ff <= prod_bc_in;
         prod_bs_ff <= prod_bs_in;
         p_mid_ff   <= p;
         u_ff       <= u_in;
         v_ff       <= v_in;
         p_out_ff   <= p_mid_ff;
      end
   end

   assign out_valid = valid_out_ff;
   assign u         = u_ff;
   assign v         = v_ff;
   assign p_out     = p_out_ff;

endmodule

### design/evr_sat_stage.sv
// ----------------------------------------------------------------------------
// evr_sat_stage
// Output register: saturates the three wide coordinates to the payload
// width and holds the response until taken.
// ----------------------------------------------------------------------------
module evr_sat_stage #(
   parameter int IW = evr_pkg::COORD_WIDTH + 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [IW-1:0]     x,
   input  logic signed [IW-1:0]     y,
   input  logic signed [IW-1:0]     z,
   output logic                     out_valid,
   output evr_pkg::rsp_payload_type out_payload
);

   localparam int CW = evr_pkg::COORD_WIDTH;

   logic                     valid_ff;
   evr_pkg::rsp_payload_type payload_in, payload_ff;

   function automatic logic signed [CW-1:0] sat(input logic signed [IW-1:0] val);
      logic fits;
      fits = (&val[IW-1:CW-1]) | ~(|val[IW-1:CW-1]);
      if (fits)
         sat = val[CW-1:0];
      else if (val[IW-1])
         sat = {1'b1, {(CW-1){1'b0}}};
      else
         sat = {1'b0, {(CW-1){1'b1}}};
   endfunction

   always_comb begin
      payload_in.rot_x = sat(x);
      payload_in.rot_y = sat(y);
      payload_in.rot_z = sat(z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         payload_ff <= payload_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_payload = payload_ff;

endmodule
